// ----- rtl/core/homogeneous_point_transform_macros.svh -----
// Assertion macros shared by the point transform RTL.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define HPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point transform check failed");

// Check a condition in the cycle after its trigger.
`define HPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point transform check failed");

`endif

// ----- rtl/core/hpt_pkg.sv -----
// Shared types, constants and helpers of the point transform.
package hpt_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int IDX_W    = 8;
    localparam int SUM_W    = 66;
    localparam int REM_W    = 66;
    localparam int QUO_W    = 32;
    localparam int NUM_CELLS = QUO_W;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] hpt_mat_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] num_lo;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } hpt_lane_t;

    typedef struct packed {
        logic             valid;
        logic             wzero;
        logic [REM_W-1:0] dmag;
        hpt_lane_t [2:0]  lane;
    } hpt_item_t;

    // Pick one signed Q16.16 coefficient out of the register file.
    function automatic logic signed [DATA_W-1:0] hpt_coef(
        input hpt_mat_t m, input int r, input int c);
        logic [REG_W-1:0] word;
        word = m[r*2 + c/2];
        return (c % 2 == 1) ? $signed(word[31:0]) : $signed(word[63:32]);
    endfunction

endpackage

// ----- rtl/core/homogeneous_point_transform.sv -----
// Results are computed by the front stages and a 32-cell division chain,
// one quotient bit per cell. Throughput: one point per cycle; a stalled
// output stalls the whole pipeline.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads
// the identity matrix into the configuration registers.
module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*DATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
    output logic [1:0]            m_tuser,   // w_is_zero, saturated
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]      cfg_data
);

`include "homogeneous_point_transform_macros.svh"

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    hpt_mat_t           mat_reg;
    hpt_item_t          chain [NUM_CELLS+1];
    logic               advance;
    logic               out_valid_reg;
    logic [3*DATA_W-1:0] out_data_reg;
    logic [1:0]         out_user_reg;
    logic [3*DATA_W-1:0] out_data_next;
    logic [1:0]         out_user_next;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Write configuration registers; drop writes beyond the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'h0001_0000_0000_0000;
            mat_reg[1] <= 64'h0;
            mat_reg[2] <= 64'h0000_0000_0001_0000;
            mat_reg[3] <= 64'h0;
            mat_reg[4] <= 64'h0;
            mat_reg[5] <= 64'h0001_0000_0000_0000;
            mat_reg[6] <= 64'h0;
            mat_reg[7] <= 64'h0000_0000_0001_0000;
        end
        else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    hpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_point (s_tdata),
        .mat      (mat_reg),
        .item     (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        hpt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .d       (chain[i]),
            .q       (chain[i+1])
        );
    end

    // Apply sign, clamp and the zero-w case.
    always_comb
    begin
        logic [DATA_W-1:0] quo;
        logic              sat;
        logic              any_sat;
        out_data_next = '0;
        any_sat       = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            quo = chain[NUM_CELLS].lane[r].quo;
            sat = chain[NUM_CELLS].lane[r].ovf
                || (chain[NUM_CELLS].lane[r].neg ? (quo > MAX_NEG) : (quo > MAX_POS));
            any_sat = any_sat | sat;
            if (sat)
                out_data_next[r*DATA_W +: DATA_W] =
                    chain[NUM_CELLS].lane[r].neg ? MAX_NEG : MAX_POS;
            else
                out_data_next[r*DATA_W +: DATA_W] =
                    chain[NUM_CELLS].lane[r].neg ? -quo : quo;
        end
        if (chain[NUM_CELLS].wzero)
        begin
            out_data_next = '0;
            out_user_next = 2'b01;
        end
        else
        begin
            out_user_next = {any_sat, 1'b0};
        end
    end

    // Hold the result until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[NUM_CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `HPT_ASSERT_NOW(a_wzero_clean, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])
    `HPT_ASSERT_NOW(a_sat_clamped, m_tvalid && m_tuser[1],
        (m_tdata[31:0] == MAX_POS) || (m_tdata[31:0] == MAX_NEG) ||
        (m_tdata[63:32] == MAX_POS) || (m_tdata[63:32] == MAX_NEG) ||
        (m_tdata[95:64] == MAX_POS) || (m_tdata[95:64] == MAX_NEG))
    `HPT_ASSERT_NEXT(a_chain_out, chain[NUM_CELLS].valid && advance, m_tvalid)

endmodule

// ----- rtl/core/hpt_front.sv -----
// Matrix multiply, row sums and divider setup of the point transform.
module hpt_front
    import hpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [3*DATA_W-1:0]      in_point,
    input  hpt_mat_t                 mat,
    output hpt_item_t                item
);

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DATA_W-1:0] p_reg [3];
    logic signed [63:0] prod_reg [4][3];
    logic signed [SUM_W-1:0] sum_reg [4];
    logic [SUM_W-1:0]  mag_reg [4];
    logic              sgn_reg [4];
    logic              wz_reg;
    hpt_item_t         item_reg;
    hpt_item_t         item_next;

    // Advance the valid flags of the front stages and the seeded item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            item_reg <= '0;
        end
        else if (advance)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            item_reg <= item_next;
        end
    end

    // Capture the point, form products, row sums and magnitudes.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 3; c++)
                p_reg[c] <= in_point[c*DATA_W +: DATA_W];
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= hpt_coef(mat, r, c) * $signed(p_reg[c]);
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                            + SUM_W'(prod_reg[r][2])
                            + (SUM_W'(hpt_coef(mat, r, 3)) <<< FRAC_W);
                sgn_reg[r] <= sum_reg[r][SUM_W-1];
                mag_reg[r] <= sum_reg[r][SUM_W-1] ? SUM_W'(-sum_reg[r])
                                                  : SUM_W'(sum_reg[r]);
            end
            wz_reg <= (sum_reg[3] == '0);
        end
    end

    // Seed each divider lane: upper numerator bits as remainder, overflow check.
    always_comb
    begin
        item_next       = item_reg;
        item_next.valid = v4_reg;
        item_next.wzero = wz_reg;
        item_next.dmag  = mag_reg[3];
        for (int r = 0; r < 3; r++)
        begin
            item_next.lane[r].rem    = REM_W'(mag_reg[r][SUM_W-1:FRAC_W]);
            item_next.lane[r].num_lo = {mag_reg[r][FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
            item_next.lane[r].quo    = '0;
            item_next.lane[r].neg    = sgn_reg[r] ^ sgn_reg[3];
            item_next.lane[r].ovf    = REM_W'(mag_reg[r][SUM_W-1:FRAC_W]) >= mag_reg[3];
        end
    end

    assign item = item_reg;

endmodule

// ----- rtl/core/hpt_cell.sv -----
// One restoring-division cell: one quotient bit for each of three lanes.
module hpt_cell
    import hpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  hpt_item_t d,
    output hpt_item_t q
);

    hpt_item_t q_reg;
    hpt_item_t q_next;

    // Shift in one numerator bit and subtract the divisor where it fits.
    always_comb
    begin
        logic [REM_W:0] part;
        logic [REM_W:0] trial;
        q_next = d;
        for (int r = 0; r < 3; r++)
        begin
            part  = {d.lane[r].rem, d.lane[r].num_lo[QUO_W-1]};
            trial = part - {1'b0, d.dmag};
            q_next.lane[r].num_lo = {d.lane[r].num_lo[QUO_W-2:0], 1'b0};
            if (!trial[REM_W])
            begin
                q_next.lane[r].rem = trial[REM_W-1:0];
                q_next.lane[r].quo = {d.lane[r].quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_next.lane[r].rem = part[REM_W-1:0];
                q_next.lane[r].quo = {d.lane[r].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Advance the item; clear it under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (advance)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- verif/homogeneous_point_transform_tb.sv -----
// Self-checking testbench for the 4x4 homogeneous point transform with perspective divide.
module homogeneous_point_transform_tb
    import hpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              w_zero;
        logic              sat;
    } vertex_t;

    localparam logic [DATA_W-1:0] ONE_Q  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] MAX_Q  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_Q  = 32'h8000_0000;
    localparam int                OUT_HOLD_AT = 400;
    localparam int                OUT_HOLD_LEN = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [3*DATA_W-1:0]  s_tdata;   // point_x, point_y, point_z
    logic                 m_tvalid;
    logic                 m_tready;
    logic [3*DATA_W-1:0]  m_tdata;   // out_x, out_y, out_z
    logic [1:0]           m_tuser;   // w_is_zero, saturated
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [REG_W-1:0]     cfg_data;

    logic [REG_W-1:0]     matrix_regs [NUM_REGS];
    logic [3*DATA_W-1:0]  point_queue [$];
    vertex_t              vertex_queue [$];
    logic                 s_took;
    int                   tx_gap;
    int                   rx_gap;
    int                   vertices_seen;
    bit                   out_held;
    bit                   no_idle;
    int                   errors;

    homogeneous_point_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Signed coefficient of the shadow matrix
    function automatic logic signed [DATA_W-1:0] matrix_coef(input int r, input int c);
        logic [REG_W-1:0] word;
        word = matrix_regs[r*2 + c/2];
        return (c % 2 == 1) ? $signed(word[31:0]) : $signed(word[63:32]);
    endfunction

    // Transform one point: exact row sums, divide by w toward zero, clamp
    function automatic vertex_t project_vertex(input logic [3*DATA_W-1:0] pt);
        logic signed [127:0] sums [4];
        logic signed [127:0] cf;
        logic signed [127:0] pv;
        logic signed [127:0] quo;
        logic signed [DATA_W-1:0] comp;
        logic [DATA_W-1:0] outs [3];
        vertex_t v;
        for (int r = 0; r < 4; r++)
        begin
            cf = matrix_coef(r, 3);
            sums[r] = cf <<< FRAC_W;
            for (int c = 0; c < 3; c++)
            begin
                comp = pt[c*DATA_W +: DATA_W];
                cf = matrix_coef(r, c);
                pv = comp;
                sums[r] = sums[r] + cf * pv;
            end
        end
        v.sat = 1'b0;
        v.w_zero = (sums[3] == 0);
        for (int i = 0; i < 3; i++)
        begin
            outs[i] = '0;
            if (!v.w_zero)
            begin
                quo = (sums[i] <<< FRAC_W) / sums[3];
                if (quo > $signed(128'sh7FFF_FFFF))
                begin
                    outs[i] = MAX_Q;
                    v.sat = 1'b1;
                end
                else if (quo < -$signed(128'sh8000_0000))
                begin
                    outs[i] = MIN_Q;
                    v.sat = 1'b1;
                end
                else
                    outs[i] = quo[DATA_W-1:0];
            end
        end
        v.x = outs[0];
        v.y = outs[1];
        v.z = outs[2];
        return v;
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $urandom_range(0, 1) ? MAX_Q : MIN_Q;
            default: return $signed($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_coef(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $urandom_range(0, 1) ? MAX_Q : MIN_Q;
            default: return '0;
        endcase
    endfunction

    // Write one register over the configuration channel
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            matrix_regs[idx] = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (point_queue.size() != 0 || s_tvalid || vertex_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic queue_point(input logic [DATA_W-1:0] x, y, z);
        point_queue.push_back({z, y, x});
    endtask

    // Send request: refill on acceptance, insert random gaps
    always @(posedge clk)
        s_took <= s_tvalid && s_tready;

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (point_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= point_queue.pop_front();
                tx_gap   <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!out_held && vertices_seen >= OUT_HOLD_AT)
            begin
                out_held <= 1'b1;
                m_tready <= 1'b0;
                rx_gap   <= OUT_HOLD_LEN;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap   <= pick_gap();
            end
        end
    end

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        vertex_t exp_v;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                vertex_queue.push_back(project_vertex(s_tdata));
            if (m_tvalid && m_tready)
            begin
                vertices_seen <= vertices_seen + 1;
                if (vertex_queue.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_v = vertex_queue.pop_front();
                    if (m_tdata[31:0] !== exp_v.x)
                    begin
                        $error("out_x exp %h got %h", exp_v.x, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== exp_v.y)
                    begin
                        $error("out_y exp %h got %h", exp_v.y, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[95:64] !== exp_v.z)
                    begin
                        $error("out_z exp %h got %h", exp_v.z, m_tdata[95:64]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_v.w_zero)
                    begin
                        $error("w_is_zero exp %b got %b", exp_v.w_zero, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_v.sat)
                    begin
                        $error("saturated exp %b got %b", exp_v.sat, m_tuser[1]);
                        errors++;
                    end
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

    // Reset, directed points, then random matrices and points
    initial
    begin
        int coef_mode;
        int pt_mode;
        int count;
        logic [DATA_W-1:0] cf [4][4];
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_took = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        vertices_seen = 0;
        out_held = 1'b0;
        no_idle = 1'b0;
        errors = 0;
        matrix_regs = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
                        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity after reset: field extremes pass straight through
        queue_point('0, '0, '0);
        queue_point(MAX_Q, MIN_Q, 32'hFFFF_FFFF);
        queue_point(MIN_Q, MAX_Q, 32'h1);
        queue_point(ONE_Q, -ONE_Q, 32'h5555_AAAA);
        queue_point(32'hAAAA_5555, MAX_Q, MIN_Q);
        wait_idle();

        // Scaled w and large row 0: saturation both ways
        write_reg(0, {MAX_Q, MAX_Q});
        write_reg(7, {32'h0, 32'h0000_0100});
        queue_point(MAX_Q, MAX_Q, MAX_Q);
        queue_point(MIN_Q, MIN_Q, '0);
        queue_point(ONE_Q, '0, '0);
        wait_idle();
        // Negative w
        write_reg(7, {MIN_Q, MIN_Q});
        queue_point(ONE_Q, MIN_Q, MAX_Q);
        queue_point('0, '0, '0);
        queue_point(MIN_Q, MAX_Q, ONE_Q);
        wait_idle();

        // w depends only on x: zero w whenever x is zero
        write_reg(6, {ONE_Q, 32'h0});
        write_reg(7, 64'h0);
        queue_point('0, MAX_Q, MIN_Q);
        queue_point(ONE_Q, MAX_Q, MIN_Q);
        queue_point('0, ONE_Q, ONE_Q);
        queue_point(-ONE_Q, '0, ONE_Q);
        wait_idle();
        // Index past the register file is ignored
        write_reg(8, 64'hDEAD_BEEF_0000_0001);
        write_reg(255, 64'h0);
        queue_point('0, '0, '0);
        queue_point(32'h7, 32'h3, 32'h1);
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            coef_mode = (ph < 2) ? 1 : $urandom_range(0, 3);
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    cf[r][c] = ($urandom_range(0, 3) == 0) ? rand_coef($urandom_range(0, 3))
                                                           : rand_coef(coef_mode);
            // Some phases make w collapse to zero often
            if (ph % 4 == 3)
            begin
                cf[3][1] = '0;
                cf[3][2] = '0;
                cf[3][3] = '0;
            end
            if (ph == 5)
                cf[3] = '{default: '0};
            if (ph == 8)
                cf = '{default: MAX_Q};
            if (ph == 9)
                cf = '{default: MIN_Q};
            for (int r = 0; r < 4; r++)
            begin
                write_reg(IDX_W'(2*r), {cf[r][0], cf[r][1]});
                write_reg(IDX_W'(2*r + 1), {cf[r][2], cf[r][3]});
            end
            no_idle = (ph % 3 == 1);
            count = $urandom_range(140, 170);
            for (int n = 0; n < count; n++)
            begin
                pt_mode = $urandom_range(0, 4);
                if (ph % 4 == 3 && pt_mode == 4)
                    queue_point('0, rand_coord($urandom_range(0, 3)),
                                rand_coord($urandom_range(0, 3)));
                else
                    queue_point(rand_coord(pt_mode % 4), rand_coord($urandom_range(0, 3)),
                                rand_coord($urandom_range(0, 3)));
            end
            wait_idle();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_front.sv
rtl/core/hpt_cell.sv
rtl/core/homogeneous_point_transform.sv
verif/homogeneous_point_transform_tb.sv
